// ===== sv/fsas_pkg.sv =====
// Package of types and constants for the single-precision add/subtract unit.
package fsas_pkg;

	typedef struct packed {
		logic        kind;
		logic [31:0] operand_a;
		logic [31:0] operand_b;
	} req_t;

	typedef struct packed {
		logic [31:0] sum_bits;
		logic [1:0]  status;
	} rsp_t;

	localparam logic [1:0] STAT_NORMAL    = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
	localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

	localparam logic [7:0] EXP_ALL_ONES = 8'hFF;

	// Aligned operands after the first stage.
	typedef struct packed {
		logic        sign;
		logic        unlike;
		logic        cancel;
		logic [7:0]  ebig;
		logic [23:0] mbig;
		logic [23:0] msmall;
	} align_t;

	// Raw sum or difference after the second stage.
	typedef struct packed {
		logic        sign;
		logic        unlike;
		logic        zero;
		logic [7:0]  ebig;
		logic [24:0] m;
	} sum_t;

endpackage

// ===== sv/float_single_add_sub_unit.sv =====
// Top level of the pipelined single-precision add/subtract unit.
// A request passes through the aligned-operand, raw-sum and result registers in order;
// its result then waits at the output until it is taken.
// Throughput: one request per cycle while the output is not stalled; the three register
// stages are set by alignment, mantissa add and renormalisation.
// A stall at the output freezes the whole pipeline; nothing is lost.
// Reset (arst_n, asynchronous) clears the stage valid bits only.
module float_single_add_sub_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  fsas_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output fsas_pkg::rsp_t out_data
);
	import fsas_pkg::*;

	// The pipeline moves as a whole whenever the last stage is free.
	logic   adv;
	align_t aln, aln_s1;
	sum_t   sm, sm_s2;
	rsp_t   rsp;
	logic   v_s1, v_s2, v_s3;

	assign adv      = !(v_s3 && out_stall);
	assign in_stall = !adv;

	fsas_align u_align (.req(in_data), .aln(aln));

	// Stage two forms the sum of like signs or the difference of unlike ones.
	always_comb begin
		sm.sign   = aln_s1.sign;
		sm.unlike = aln_s1.unlike;
		sm.ebig   = aln_s1.ebig;
		if (aln_s1.unlike)
			sm.m = {1'b0, aln_s1.mbig - aln_s1.msmall};
		else
			sm.m = {1'b0, aln_s1.mbig} + {1'b0, aln_s1.msmall};
		sm.zero = aln_s1.unlike && (aln_s1.cancel || sm.m == 25'd0);
	end

	fsas_norm u_norm (.sm(sm_s2), .rsp(rsp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			aln_s1   <= aln;
			sm_s2    <= sm;
			out_data <= rsp;
		end
	end

	assign out_valid = v_s3;

	// A stalled result must hold until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");
	// Requests advance one stage per free cycle.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && adv |=> v_s3)
		else $error("request lost between stages");
	// A valid result never carries an undefined status code.
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != 2'd3)
		else $error("bad status");
endmodule

// ===== sv/fsas_align.sv =====
// First stage logic: sign handling, magnitude ordering and mantissa alignment.
module fsas_align (
	input  fsas_pkg::req_t   req,
	output fsas_pkg::align_t aln
);
	import fsas_pkg::*;

	logic [31:0] b;
	logic [31:0] big, sml;
	logic [7:0]  shift;
	logic [23:0] msml;

	always_comb begin
		b = req.operand_b ^ {req.kind, 31'd0};
		if (req.operand_a[30:0] >= b[30:0]) begin
			big = req.operand_a;
			sml = b;
		end else begin
			big = b;
			sml = req.operand_a;
		end
		shift = big[30:23] - sml[30:23];
		msml  = {1'b1, sml[22:0]};
		aln.sign   = big[31];
		aln.unlike = req.operand_a[31] ^ b[31];
		aln.cancel = req.operand_a[30:0] == b[30:0];
		aln.ebig   = big[30:23];
		aln.mbig   = {1'b1, big[22:0]};
		aln.msmall = (shift >= 8'd24) ? 24'd0 : (msml >> shift[4:0]);
	end
endmodule

// ===== sv/fsas_norm.sv =====
// Third stage logic: renormalisation, exponent range checks and packing.
module fsas_norm (
	input  fsas_pkg::sum_t sm,
	output fsas_pkg::rsp_t rsp
);
	import fsas_pkg::*;

	logic [4:0]  lz;
	logic [23:0] m;
	logic [9:0]  e;

	always_comb begin
		lz = 5'd0;
		for (int i = 0; i < 24; i++) begin
			if (sm.m[i]) lz = 5'(23 - i);
		end
		if (!sm.unlike && sm.m[24]) begin
			m = sm.m[24:1];
			e = {2'b00, sm.ebig} + 10'd1;
		end else if (sm.unlike) begin
			m = sm.m[23:0] << lz;
			e = {2'b00, sm.ebig} - {5'd0, lz};
		end else begin
			m = sm.m[23:0];
			e = {2'b00, sm.ebig};
		end
		if (sm.zero) begin
			rsp.sum_bits = 32'd0;
			rsp.status   = STAT_NORMAL;
		end else if (!e[9] && e[8:0] >= 9'd255) begin
			rsp.sum_bits = {sm.sign, EXP_ALL_ONES, 23'd0};
			rsp.status   = STAT_OVERFLOW;
		end else if (e[9] || e == 10'd0) begin
			rsp.sum_bits = {sm.sign, 31'd0};
			rsp.status   = STAT_UNDERFLOW;
		end else begin
			rsp.sum_bits = {sm.sign, e[7:0], m[22:0]};
			rsp.status   = STAT_NORMAL;
		end
	end
endmodule
